// ----- src/bcsim_pkg.sv -----
package bcsim_pkg;

    // index and process widths of the mapper
    localparam int INDEX_BITS = 20;
    localparam int PROC_BITS  = 8;

    localparam int SIZE_BITS  = 16;
    localparam int OUT_BITS   = 24;
    localparam int NP_BITS    = PROC_BITS + 1;
    localparam int ADDR_BITS  = 5;
    localparam int REG_BITS   = 3;

    // widths of the exact intermediate results
    localparam int GB_BITS    = INDEX_BITS + NP_BITS;
    localparam int G_BITS     = INDEX_BITS + NP_BITS + SIZE_BITS;
    localparam int BASE_BITS  = INDEX_BITS + 1;
    localparam int DIV_BITS   = (SIZE_BITS > NP_BITS) ? SIZE_BITS : NP_BITS;

    // stream payload widths, padded to whole bytes
    localparam int IN_DATA_BITS  = ((INDEX_BITS + 7) / 8) * 8;
    localparam int OUT_RAW_BITS  = OUT_BITS + OUT_BITS + INDEX_BITS;
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

    // pipeline stage map
    localparam int S_DIV1 = (INDEX_BITS > PROC_BITS) ? INDEX_BITS : PROC_BITS;
    localparam int S_M1   = S_DIV1;
    localparam int S_M2   = S_M1 + 1;
    localparam int S_F1   = S_M2 + 1 + G_BITS;
    localparam int S_F2   = S_F1 + 1;
    localparam int S_OUT  = S_F2 + 1;
    localparam int N_STAGES = S_OUT + 1;

    // register indexes
    localparam logic [REG_BITS-1:0] REG_DIM_LENGTH = 3'd0;
    localparam logic [REG_BITS-1:0] REG_BLOCK_SIZE = 3'd1;
    localparam logic [REG_BITS-1:0] REG_TILE_SIZE  = 3'd2;
    localparam logic [REG_BITS-1:0] REG_PROC_COUNT = 3'd3;
    localparam logic [REG_BITS-1:0] REG_PROC_COORD = 3'd4;

    typedef struct packed {
        logic [INDEX_BITS-1:0] x_o;    // offset / block quotient
        logic [SIZE_BITS-1:0]  p_o;    // offset % block
        logic [INDEX_BITS-1:0] x_d;    // dim / block quotient
        logic [SIZE_BITS-1:0]  p_d;    // dim % block
        logic [PROC_BITS-1:0]  x_c;    // coord / count quotient
        logic [NP_BITS-1:0]    p_c;    // coord % count
        logic [GB_BITS-1:0]    gb;
        logic [INDEX_BITS-1:0] nblk;
        logic [G_BITS-1:0]     g;
        logic [G_BITS-1:0]     x_g;    // global / tile quotient
        logic [SIZE_BITS-1:0]  p_g;    // global % tile
        logic [INDEX_BITS-1:0] x_n;    // blocks / count quotient
        logic [NP_BITS-1:0]    p_n;    // blocks % count
        logic                  cond_a;
        logic [BASE_BITS-1:0]  base;
        logic [SIZE_BITS-1:0]  offp;
        logic [OUT_BITS-1:0]   loc;
        logic [INDEX_BITS-1:0] slab;
    } t_item;

    // one restoring division step: {new partial remainder, quotient bit}
    function automatic logic [DIV_BITS:0] f_div_step(
        input logic [DIV_BITS-1:0] p,
        input logic                xbit,
        input logic [DIV_BITS-1:0] d
    );
        logic [DIV_BITS:0] t;
        logic [DIV_BITS:0] s;
        logic              ge;
        t  = {p, xbit};
        ge = (t >= {1'b0, d});
        s  = ge ? (t - {1'b0, d}) : t;
        return {s[DIV_BITS-1:0], ge};
    endfunction

endpackage

// ----- src/block_cyclic_slab_index_mapper.sv -----
// channel   direction  handshake                      payload
// s stream  in         i_s_tvalid / o_s_tready        local_offset
// m stream  out        o_m_tvalid / i_m_tready        global_index, next_split_local, slab_length
// apb       in         i_psel, i_penable, i_pwrite    dim_length .. proc_coord
//
// one request accepted per cycle while the output is not held; each result passes
// through the bit-serial divider chains in order:
// offset / block, then global index / tile, one quotient bit per stage
// synchronous active-low reset clears the valid bits, dim and coord; sizes and count go to one
// a stall at the output freezes every stage at once, nothing dropped or doubled
module block_cyclic_slab_index_mapper
    import bcsim_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // stream in
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [IN_DATA_BITS-1:0]  i_s_tdata,   // local_offset
    // stream out
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [OUT_DATA_BITS-1:0] o_m_tdata,   // global_index, next_split_local, slab_length
    // configuration
    input  logic                     i_psel,
    input  logic                     i_penable,
    input  logic                     i_pwrite,
    input  logic [ADDR_BITS-1:0]     i_paddr,
    input  logic [31:0]              i_pwdata,
    output logic [31:0]              o_prdata,
    output logic                     o_pready
);

    // configuration registers
    logic [INDEX_BITS-1:0] r_dim;
    logic [SIZE_BITS-1:0]  r_blk;
    logic [SIZE_BITS-1:0]  r_til;
    logic [NP_BITS-1:0]    r_np;
    logic [PROC_BITS-1:0]  r_pc;

    logic [REG_BITS-1:0]   w_idx;
    logic                  w_wr;

    // zero sizes and counts behave as one
    logic [SIZE_BITS-1:0]  w_blk;
    logic [SIZE_BITS-1:0]  w_til;
    logic [NP_BITS-1:0]    w_np;

    // pipeline
    t_item                 r_st   [N_STAGES];
    t_item                 n_st   [N_STAGES];
    t_item                 w_prev [N_STAGES];
    t_item                 w_in;
    logic [N_STAGES-1:0]   r_vld;
    logic                  w_en;

    assign o_pready = 1'b1;
    assign w_idx    = i_paddr[ADDR_BITS-1:2];
    assign w_wr     = i_psel & i_penable & i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= '0;
            r_blk <= SIZE_BITS'(1);
            r_til <= SIZE_BITS'(1);
            r_np  <= NP_BITS'(1);
            r_pc  <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_DIM_LENGTH: r_dim <= i_pwdata[INDEX_BITS-1:0];
                REG_BLOCK_SIZE: r_blk <= i_pwdata[SIZE_BITS-1:0];
                REG_TILE_SIZE:  r_til <= i_pwdata[SIZE_BITS-1:0];
                REG_PROC_COUNT: r_np  <= i_pwdata[NP_BITS-1:0];
                REG_PROC_COORD: r_pc  <= i_pwdata[PROC_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_DIM_LENGTH: o_prdata = 32'(r_dim);
            REG_BLOCK_SIZE: o_prdata = 32'(r_blk);
            REG_TILE_SIZE:  o_prdata = 32'(r_til);
            REG_PROC_COUNT: o_prdata = 32'(r_np);
            REG_PROC_COORD: o_prdata = 32'(r_pc);
            default:        o_prdata = '0;
        endcase
    end

    assign w_blk = (r_blk == '0) ? SIZE_BITS'(1) : r_blk;
    assign w_til = (r_til == '0) ? SIZE_BITS'(1) : r_til;
    assign w_np  = (r_np  == '0) ? NP_BITS'(1)   : r_np;

    // whole pipeline moves together unless the output is held
    assign w_en       = !r_vld[N_STAGES-1] || i_m_tready;
    assign o_s_tready = w_en;

    // request enters the first division step with empty remainders
    always_comb begin
        w_in     = '0;
        w_in.x_o = i_s_tdata[INDEX_BITS-1:0];
        w_in.x_d = r_dim;
        w_in.x_c = r_pc;
    end

    for (genvar s = 0; s < N_STAGES; s++) begin : g_stage
        if (s == 0) begin : g_first
            assign w_prev[s] = w_in;
        end else begin : g_next
            assign w_prev[s] = r_st[s-1];
        end

        always_comb begin
            t_item                   pv;
            t_item                   nx;
            logic [DIV_BITS:0]       st;
            logic [G_BITS-1:0]       g;
            logic [G_BITS:0]         nb;
            logic [G_BITS:0]         nt;
            logic [SIZE_BITS:0]      off_b;
            logic [PROC_BITS:0]      d;
            logic [INDEX_BITS-1:0]   cnt;
            logic [NP_BITS-1:0]      last_p;
            logic [NP_BITS-1:0]      pc_w;
            pv     = w_prev[s];
            nx     = pv;
            st     = '0;
            g      = '0;
            nb     = '0;
            nt     = '0;
            off_b  = '0;
            d      = '0;
            cnt    = '0;
            last_p = '0;
            pc_w   = NP_BITS'(r_pc);
            if (s < S_DIV1) begin
                // offset and length over the block size, coordinate over the count
                if (s < INDEX_BITS) begin
                    st     = f_div_step(DIV_BITS'(pv.p_o), pv.x_o[INDEX_BITS-1],
                                        DIV_BITS'(w_blk));
                    nx.p_o = st[SIZE_BITS:1];
                    nx.x_o = (pv.x_o << 1) | INDEX_BITS'(st[0]);
                    st     = f_div_step(DIV_BITS'(pv.p_d), pv.x_d[INDEX_BITS-1],
                                        DIV_BITS'(w_blk));
                    nx.p_d = st[SIZE_BITS:1];
                    nx.x_d = (pv.x_d << 1) | INDEX_BITS'(st[0]);
                end
                if (s < PROC_BITS) begin
                    st     = f_div_step(DIV_BITS'(pv.p_c), pv.x_c[PROC_BITS-1],
                                        DIV_BITS'(w_np));
                    nx.p_c = st[NP_BITS:1];
                    nx.x_c = (pv.x_c << 1) | PROC_BITS'(st[0]);
                end
            end else if (s == S_M1) begin
                // global block number and block count of the dimension
                nx.gb   = GB_BITS'(GB_BITS'(pv.x_o) * GB_BITS'(w_np) + GB_BITS'(r_pc));
                nx.nblk = pv.x_d + INDEX_BITS'(pv.p_d != '0);
            end else if (s == S_M2) begin
                g      = G_BITS'(G_BITS'(pv.gb) * G_BITS'(w_blk)) + G_BITS'(pv.p_o);
                nx.g   = g;
                nx.x_g = g;
                nx.p_g = '0;
                nx.x_n = pv.nblk;
                nx.p_n = '0;
            end else if (s < S_F1) begin
                // global index over the tile, block count over the process count
                st     = f_div_step(DIV_BITS'(pv.p_g), pv.x_g[G_BITS-1], DIV_BITS'(w_til));
                nx.p_g = st[SIZE_BITS:1];
                nx.x_g = (pv.x_g << 1) | G_BITS'(st[0]);
                if ((s - S_M2 - 1) < INDEX_BITS) begin
                    st     = f_div_step(DIV_BITS'(pv.p_n), pv.x_n[INDEX_BITS-1],
                                        DIV_BITS'(w_np));
                    nx.p_n = st[NP_BITS:1];
                    nx.x_n = (pv.x_n << 1) | INDEX_BITS'(st[0]);
                end
            end else if (s == S_F1) begin
                // next block boundary against next tile boundary
                nb = (G_BITS+1)'(pv.g) - (G_BITS+1)'(pv.p_o) + (G_BITS+1)'(w_blk);
                nt = (G_BITS+1)'(pv.g) - (G_BITS+1)'(pv.p_g) + (G_BITS+1)'(w_til);
                off_b = (SIZE_BITS+1)'(pv.p_o) - (SIZE_BITS+1)'(pv.p_g)
                      + (SIZE_BITS+1)'(w_til);
                nx.cond_a = (nb <= nt);
                // extra local blocks passed when the split is moved to an own block
                if (nb <= nt) begin
                    d = (PROC_BITS+1)'(pv.x_c) + (PROC_BITS+1)'(1);
                end else begin
                    d = (PROC_BITS+1)'(pv.x_c)
                      + (PROC_BITS+1)'((pc_w >= w_np) && (pv.p_c != '0));
                end
                nx.base = BASE_BITS'(pv.x_o) + BASE_BITS'(d);
                nx.offp = (nb <= nt) ? '0 : off_b[SIZE_BITS-1:0];
            end else if (s == S_F2) begin
                nx.loc  = OUT_BITS'((BASE_BITS+SIZE_BITS)'(pv.base)
                        * (BASE_BITS+SIZE_BITS)'(w_blk)
                        + (BASE_BITS+SIZE_BITS)'(pv.offp));
                cnt     = pv.x_n + INDEX_BITS'(pv.p_n != '0);
                nx.slab = INDEX_BITS'((INDEX_BITS+SIZE_BITS)'(cnt)
                        * (INDEX_BITS+SIZE_BITS)'(w_blk));
            end else begin
                // partial last block and short slabs
                last_p = ((pv.p_n == '0) ? w_np : pv.p_n) - NP_BITS'(1);
                if ((pc_w == last_p) && (pv.p_d != '0)) begin
                    nx.slab = pv.slab - INDEX_BITS'(w_blk) + INDEX_BITS'(pv.p_d);
                end else if ((pv.p_n != '0) && (pc_w >= pv.p_n)) begin
                    nx.slab = pv.slab - INDEX_BITS'(w_blk);
                end
            end
            n_st[s] = nx;
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[N_STAGES-2:0], i_s_tvalid};
        end
    end

    assign o_m_tvalid = r_vld[N_STAGES-1];
    assign o_m_tdata  = OUT_DATA_BITS'({r_st[N_STAGES-1].slab,
                                        r_st[N_STAGES-1].loc,
                                        r_st[N_STAGES-1].g[OUT_BITS-1:0]});

`ifndef SYNTHESIS
    // a held output freezes the valid bits of every stage
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("valid bits moved during a stall");

    // offset remainder stays below the block size
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[S_M1] |-> (r_st[S_M1].p_o < w_blk))
        else $error("offset remainder not below block size");

    // a tile split inside the block lands within that block
    a_tile_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[S_F1] && !r_st[S_F1].cond_a) |-> (r_st[S_F1].offp < w_blk))
        else $error("tile split outside its block");
`endif

endmodule

// ----- sim/block_cyclic_slab_index_mapper_chk.sv -----
module block_cyclic_slab_index_mapper_chk
    import bcsim_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    input  logic                     i_s_tready,
    input  logic [IN_DATA_BITS-1:0]  i_s_tdata,
    input  logic                     i_m_tvalid,
    input  logic                     i_m_tready,
    input  logic [OUT_DATA_BITS-1:0] i_m_tdata,
    input  logic                     i_psel,
    input  logic                     i_penable,
    input  logic                     i_pwrite,
    input  logic [ADDR_BITS-1:0]     i_paddr,
    input  logic [31:0]              i_pwdata,
    output int                       o_errors,
    output int                       o_pending,
    output int                       o_results
);

    typedef struct packed {
        logic [OUT_BITS-1:0]   gidx;
        logic [OUT_BITS-1:0]   split;
        logic [INDEX_BITS-1:0] slab;
    } t_map;

    logic [63:0] dim_q, blk_q, til_q, np_q, coord_q;
    t_map        map_q[$];

    // mapping of one local offset, exact in 64 bits, then wrapped
    function automatic t_map map_offset(logic [63:0] off);
        logic [63:0] b, t, p, g, nb, nt, n, nblk, slab, remp, reml, lastp, len, loc;
        t_map r;
        b = (blk_q == 0) ? 64'd1 : blk_q;
        t = (til_q == 0) ? 64'd1 : til_q;
        p = (np_q == 0) ? 64'd1 : np_q;
        g = ((off / b) * p + coord_q) * b + off % b;
        nb = (g / b + 1) * b;
        nt = (g / t + 1) * t;
        n = (nb < nt) ? nb : nt;
        if ((n / b) % p != coord_q) n = n + (p - 1) * b;
        nblk = (dim_q + b - 1) / b;
        slab = ((nblk + p - 1) / p) * b;
        remp = nblk % p;
        reml = dim_q % b;
        lastp = ((remp == 0) ? p : remp) - 1;
        if (coord_q == lastp && reml != 0) len = slab - b + reml;
        else if (remp != 0 && coord_q > remp - 1) len = slab - b;
        else len = slab;
        loc = ((n / b) / p) * b + n % b;
        r.gidx = g[OUT_BITS-1:0];
        r.split = loc[OUT_BITS-1:0];
        r.slab = len[INDEX_BITS-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_map want, got;
        if (!i_rst_n) begin
            dim_q <= '0; blk_q <= 64'd1; til_q <= 64'd1; np_q <= 64'd1; coord_q <= '0;
            o_errors <= 0; o_results <= 0;
            map_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite) begin
                case (i_paddr[ADDR_BITS-1:2])
                    REG_DIM_LENGTH: dim_q <= 64'(i_pwdata[INDEX_BITS-1:0]);
                    REG_BLOCK_SIZE: blk_q <= 64'(i_pwdata[SIZE_BITS-1:0]);
                    REG_TILE_SIZE:  til_q <= 64'(i_pwdata[SIZE_BITS-1:0]);
                    REG_PROC_COUNT: np_q  <= 64'(i_pwdata[NP_BITS-1:0]);
                    REG_PROC_COORD: coord_q <= 64'(i_pwdata[PROC_BITS-1:0]);
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                map_q.push_back(map_offset(64'(i_s_tdata[INDEX_BITS-1:0])));
            if (i_m_tvalid && i_m_tready) begin
                o_results <= o_results + 1;
                got.gidx  = i_m_tdata[OUT_BITS-1:0];
                got.split = i_m_tdata[2*OUT_BITS-1:OUT_BITS];
                got.slab  = i_m_tdata[2*OUT_BITS+INDEX_BITS-1:2*OUT_BITS];
                if (map_q.size() == 0) begin
                    $display("%0t unexpected result %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = map_q.pop_front();
                    if (got.gidx !== want.gidx || got.split !== want.split ||
                        got.slab !== want.slab) begin
                        $display("%0t mismatch exp g=%0d s=%0d l=%0d act g=%0d s=%0d l=%0d",
                                 $time, want.gidx, want.split, want.slab,
                                 got.gidx, got.split, got.slab);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

    assign o_pending = map_q.size();

endmodule

// ----- sim/block_cyclic_slab_index_mapper_tb.sv -----
module block_cyclic_slab_index_mapper_tb;
    import bcsim_pkg::*;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata = '0;    // local_offset
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;         // global_index, next_split_local, slab_length
    logic                     psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_BITS-1:0]     paddr = '0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;
    int                       errors, pending, results;
    int                       idle_cycles = 0;
    int                       n_sent = 0;
    int                       sink_gap = 0;
    bit                       sink_on = 1'b0;

    localparam int WATCHDOG = 20000;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    block_cyclic_slab_index_mapper uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .o_prdata(prdata), .o_pready(pready)
    );

    block_cyclic_slab_index_mapper_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // output side back-pressure, random gaps while enabled
    always @(posedge i_clk) begin
        if (!sink_on) begin
            m_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            m_tready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else begin
            m_tready <= 1'b1;
            sink_gap <= gap_len();
        end
    end

    // watchdog on cycles with no accepted request, result or register access
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("timeout");
            $display("FAIL");
            $finish;
        end
    end

    // two-phase apb write
    task automatic reg_write(input logic [REG_BITS-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic set_map(input int dim, input int blk, input int til,
                           input int np, input int coord);
        reg_write(REG_DIM_LENGTH, dim);
        reg_write(REG_BLOCK_SIZE, blk);
        reg_write(REG_TILE_SIZE, til);
        reg_write(REG_PROC_COUNT, np);
        reg_write(REG_PROC_COORD, coord);
    endtask

    // one request, held until accepted, then a random gap
    task automatic send_offset(input logic [INDEX_BITS-1:0] off);
        int g;
        s_tvalid <= 1'b1;
        s_tdata <= off;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        n_sent++;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // drain the pipeline before touching the registers
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (N_STAGES + 4) @(posedge i_clk);
    endtask

    task automatic random_phase(input int count, input int offmax);
        repeat (count) send_offset(INDEX_BITS'($urandom_range(0, offmax)));
        drain();
    endtask

    int dim, blk, np;

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sink_on <= 1'b1;

        // reset settings, offset extremes
        send_offset('0);
        send_offset('1);
        send_offset(20'h55555);
        send_offset(20'haaaaa);
        drain();
        // zero sizes and zero count treated as one
        set_map(100, 0, 0, 0, 0);
        send_offset(20'd0); send_offset(20'd7); send_offset(20'd99);
        drain();
        // coordinate not below the count
        set_map(1000, 7, 3, 4, 9);
        send_offset(20'd0); send_offset(20'd6); send_offset(20'd13);
        drain();
        // widest settings, wrapping results
        set_map(20'hfffff, 16'hffff, 16'hffff, 256, 255);
        send_offset('1); send_offset(20'h0fffe); send_offset(20'd0); send_offset(20'h10000);
        drain();
        // partial last block on the last process
        set_map(103, 10, 4, 3, 1);
        send_offset(20'd0); send_offset(20'd9); send_offset(20'd10); send_offset(20'd33);
        drain();
        set_map(103, 10, 4, 3, 2);
        send_offset(20'd29); send_offset(20'd30);
        drain();

        // random phases; mostly small sizes, some wide
        repeat (24) begin
            if ($urandom_range(0, 5) == 0) begin
                dim = $urandom_range(0, 20'hfffff);
                blk = $urandom_range(0, 16'hffff);
                np  = $urandom_range(0, 511);
            end else begin
                dim = $urandom_range(0, 5000);
                blk = $urandom_range(1, 40);
                np  = $urandom_range(1, 16);
            end
            set_map(dim, blk, $urandom_range(0, ($urandom_range(0, 3) == 0) ? 65535 : 50),
                    np, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(0, (np > 1) ? np - 1 : 0));
            random_phase(50, ($urandom_range(0, 3) == 0) ? 20'hfffff : 2000);
        end

        $display("sent %0d offsets over 29 register settings, %0d results checked",
                 n_sent, results);
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
